FILE: src/tffv_pkg.sv
package tffv_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DATA_W            = 32;
   localparam int GAMMA_W           = 18;
   localparam int LIGHT_W           = 25;
   localparam int CSR_IDX_W         = 4;
   localparam int WIDE_W            = 66;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT = CSR_IDX_W'(1);

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(43691);
   localparam logic [LIGHT_W-1:0] LIGHT_RESET = LIGHT_W'(65536);

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [DATA_W-1:0] rho;
      logic signed [DATA_W-1:0] en;
      logic signed [DATA_W-1:0] ey;
      logic signed [DATA_W-1:0] ez;
      logic signed [DATA_W-1:0] by;
      logic signed [DATA_W-1:0] bz;
      logic                     last;
      logic                     bad;
   } side_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(S32_MAX);
      lo = WIDE_W'(S32_MIN);
      if (x > hi) begin
         return S32_MAX;
      end else if (x < lo) begin
         return S32_MIN;
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

FILE: src/tffv_div.sv
module tffv_div #(
   parameter int FRAC_BITS = tffv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [tffv_pkg::DATA_W-1:0]  numer,
   input  logic signed [tffv_pkg::DATA_W-1:0]  denom,
   output logic                                out_valid,
   output logic signed [tffv_pkg::DATA_W-1:0]  quot
);
   import tffv_pkg::*;

   localparam int QB  = DATA_W - 1;
   localparam int REM_W = 64;

   logic signed [REM_W-1:0] num_ext;
   logic [REM_W-1:0]        mag_in;
   logic [REM_W-1:0]        den_ext;

   logic [REM_W-1:0] rem_ff [0:QB];
   logic [REM_W-1:0] rem_in [1:QB];
   logic [REM_W-1:0] den_ff [0:QB];
   logic [QB-1:0]    q_ff   [0:QB];
   logic [QB-1:0]    q_in   [1:QB];
   logic             neg_ff [0:QB];
   logic             ovf_ff [0:QB];
   logic             vld_ff [0:QB];

   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] quot_ff;
   logic signed [DATA_W-1:0] quot_in;

   assign num_ext = REM_W'(numer);
   assign mag_in  = (numer[DATA_W-1] ? REM_W'(-num_ext) : REM_W'(num_ext)) << FRAC_BITS;
   assign den_ext = REM_W'($unsigned(denom));

   always_comb begin
      logic [REM_W-1:0] sub;
      for (int k = 1; k <= QB; k++) begin
         sub = den_ff[k-1] << (QB - k);
         if (rem_ff[k-1] >= sub) begin
            rem_in[k] = rem_ff[k-1] - sub;
            q_in[k]   = q_ff[k-1] | (QB'(1) << (QB - k));
         end else begin
            rem_in[k] = rem_ff[k-1];
            q_in[k]   = q_ff[k-1];
         end
      end
   end

   always_comb begin
      if (ovf_ff[QB]) begin
         quot_in = neg_ff[QB] ? S32_MIN : S32_MAX;
      end else if (neg_ff[QB]) begin
         quot_in = -$signed({1'b0, q_ff[QB]});
      end else begin
         quot_in = $signed({1'b0, q_ff[QB]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= QB; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_valid_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_in;
      den_ff[0] <= den_ext;
      q_ff[0]   <= '0;
      neg_ff[0] <= numer[DATA_W-1];
      ovf_ff[0] <= mag_in >= (den_ext << QB);
      for (int k = 1; k <= QB; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_ff[k-1];
         q_ff[k]   <= q_in[k];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
      quot_ff <= quot_in;
   end

   assign out_valid = out_valid_ff;
   assign quot      = quot_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QB] && !ovf_ff[QB] && (den_ff[QB] != '0) |-> rem_ff[QB] < den_ff[QB])
      else $error("divider remainder not below divisor");

endmodule

FILE: src/tffv_flux.sv
module tffv_flux #(
   parameter int FRAC_BITS = tffv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [tffv_pkg::DATA_W-1:0]   vel_u,
   input  logic signed [tffv_pkg::DATA_W-1:0]   vel_v,
   input  logic signed [tffv_pkg::DATA_W-1:0]   vel_w,
   input  tffv_pkg::side_type                   side,
   input  logic [tffv_pkg::GAMMA_W-1:0]         gamma_m1,
   input  logic [tffv_pkg::LIGHT_W-1:0]         c0,
   output logic                                 out_valid,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_mass,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_mom_x,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_mom_y,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_mom_z,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_energy,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_e_y,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_e_z,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_b_y,
   output logic signed [tffv_pkg::DATA_W-1:0]   flux_b_z,
   output logic                                 bad_density,
   output logic                                 last_out
);
   import tffv_pkg::*;

   localparam int NSTG = 7;
   localparam logic signed [WIDE_W-1:0] RND = (WIDE_W'(1) <<< FRAC_BITS) - WIDE_W'(1);

   typedef struct packed {
      side_type                 sd;
      logic signed [DATA_W-1:0] u;
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] uu;
      logic signed [DATA_W-1:0] vv;
      logic signed [DATA_W-1:0] ww;
      logic signed [DATA_W-1:0] ru;
      logic signed [DATA_W-1:0] q2;
      logic signed [DATA_W-1:0] ruu;
      logic signed [DATA_W-1:0] ruv;
      logic signed [DATA_W-1:0] ruw;
      logic signed [DATA_W-1:0] kin;
      logic signed [DATA_W-1:0] ek;
      logic signed [DATA_W-1:0] p;
      logic signed [DATA_W-1:0] mcz;
      logic signed [DATA_W-1:0] mcy;
      logic signed [DATA_W-1:0] momx;
      logic signed [DATA_W-1:0] enp;
      logic signed [DATA_W-1:0] mz2;
      logic signed [DATA_W-1:0] my2;
      logic signed [DATA_W-1:0] energy;
      logic signed [DATA_W-1:0] fez;
      logic signed [DATA_W-1:0] fby;
   } stage_type;

   function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic signed [WIDE_W-1:0] prod;
      logic signed [WIDE_W-1:0] adj;
      prod = WIDE_W'(a) * WIDE_W'(b);
      if (prod[WIDE_W-1]) begin
         prod = prod + RND;
      end
      adj = prod >>> FRAC_BITS;
      return sat32(adj);
   endfunction

   logic signed [DATA_W-1:0] g1_ext;
   logic signed [DATA_W-1:0] c0_ext;
   stage_type st_ff [1:NSTG];
   stage_type st_in [1:NSTG];
   logic      vld_ff [1:NSTG];
   logic signed [DATA_W:0] kin2;

   assign g1_ext = $signed({(DATA_W - GAMMA_W)'(0), gamma_m1});
   assign c0_ext = $signed({(DATA_W - LIGHT_W)'(0), c0});

   always_comb begin
      st_in[1]    = '0;
      st_in[1].sd = side;
      st_in[1].u  = vel_u;
      st_in[1].v  = vel_v;
      st_in[1].w  = vel_w;
      st_in[1].uu = fx_mul(vel_u, vel_u);
      st_in[1].vv = fx_mul(vel_v, vel_v);
      st_in[1].ww = fx_mul(vel_w, vel_w);
      st_in[1].ru = fx_mul(side.rho, vel_u);

      st_in[2]     = st_ff[1];
      st_in[2].q2  = sat32(WIDE_W'(st_ff[1].uu) + WIDE_W'(st_ff[1].vv) + WIDE_W'(st_ff[1].ww));
      st_in[2].ruu = fx_mul(st_ff[1].ru, st_ff[1].u);
      st_in[2].ruv = fx_mul(st_ff[1].ru, st_ff[1].v);
      st_in[2].ruw = fx_mul(st_ff[1].ru, st_ff[1].w);

      st_in[3]     = st_ff[2];
      kin2         = (DATA_W + 1)'(fx_mul(st_ff[2].sd.rho, st_ff[2].q2));
      st_in[3].kin = DATA_W'((kin2 + (kin2[DATA_W] ? (DATA_W + 1)'(1) : '0)) >>> 1);

      st_in[4]    = st_ff[3];
      st_in[4].ek = sat32(WIDE_W'(st_ff[3].sd.en) - WIDE_W'(st_ff[3].kin));

      st_in[5]     = st_ff[4];
      st_in[5].p   = fx_mul(g1_ext, st_ff[4].ek);
      st_in[5].mcz = fx_mul(c0_ext, st_ff[4].sd.bz);
      st_in[5].mcy = fx_mul(c0_ext, st_ff[4].sd.by);

      st_in[6]      = st_ff[5];
      st_in[6].momx = sat32(WIDE_W'(st_ff[5].ruu) + WIDE_W'(st_ff[5].p));
      st_in[6].enp  = sat32(WIDE_W'(st_ff[5].sd.en) + WIDE_W'(st_ff[5].p));
      st_in[6].mz2  = fx_mul(c0_ext, st_ff[5].mcz);
      st_in[6].my2  = fx_mul(c0_ext, st_ff[5].mcy);

      st_in[7]        = st_ff[6];
      st_in[7].energy = fx_mul(st_ff[6].enp, st_ff[6].u);
      st_in[7].fez    = sat32(-WIDE_W'(st_ff[6].my2));
      st_in[7].fby    = sat32(-WIDE_W'(st_ff[6].sd.ez));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSTG; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[1] <= in_valid;
         for (int k = 2; k <= NSTG; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NSTG; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   assign out_valid   = vld_ff[NSTG];
   assign bad_density = st_ff[NSTG].sd.bad;
   assign last_out    = st_ff[NSTG].sd.last;
   assign flux_mass   = st_ff[NSTG].sd.bad ? '0 : st_ff[NSTG].ru;
   assign flux_mom_x  = st_ff[NSTG].sd.bad ? '0 : st_ff[NSTG].momx;
   assign flux_mom_y  = st_ff[NSTG].sd.bad ? '0 : st_ff[NSTG].ruv;
   assign flux_mom_z  = st_ff[NSTG].sd.bad ? '0 : st_ff[NSTG].ruw;
   assign flux_energy = st_ff[NSTG].sd.bad ? '0 : st_ff[NSTG].energy;
   assign flux_e_y    = st_ff[NSTG].mz2;
   assign flux_e_z    = st_ff[NSTG].fez;
   assign flux_b_y    = st_ff[NSTG].fby;
   assign flux_b_z    = st_ff[NSTG].sd.ey;

endmodule

FILE: src/two_fluid_flux_vector_top.sv
// Channel   Handshake              Payload
// request   start, busy            req_density .. req_field_b_z, req_last_in
// response  rsp_valid (strobe)     rsp_flux_mass .. rsp_flux_b_z, rsp_bad_density, rsp_last_out
// csr       csr_valid, csr_ready   csr_index, csr_wdata
//
// One item enters per cycle and yields one result per item.
// The latency is set by the pipelined velocity dividers (33 stages) and seven arithmetic stages.
// Reset is synchronous and clears the valid bits and the two registers to their defaults.
// Busy and csr_ready stay constant; the receiver cannot stall a result transfer.
module two_fluid_flux_vector_top #(
   parameter int FRAC_BITS = tffv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_density,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_momentum_x,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_momentum_y,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_momentum_z,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_total_energy,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_field_e_y,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_field_e_z,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_field_b_y,
   input  logic signed [tffv_pkg::DATA_W-1:0]    req_field_b_z,
   input  logic                                  req_last_in,
   output logic                                  rsp_valid,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_mass,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_mom_x,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_mom_y,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_mom_z,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_energy,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_e_y,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_e_z,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_b_y,
   output logic signed [tffv_pkg::DATA_W-1:0]    rsp_flux_b_z,
   output logic                                  rsp_bad_density,
   output logic                                  rsp_last_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tffv_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tffv_pkg::DATA_W-1:0]           csr_wdata
);
   import tffv_pkg::*;

   localparam int DIV_LAT   = DATA_W + 1;
   localparam int TOTAL_LAT = DIV_LAT + 7;

   logic [GAMMA_W-1:0] gamma_ff;
   logic [LIGHT_W-1:0] light_ff;
   logic               accept;
   side_type           side_in;
   side_type           side_ff [1:DIV_LAT];
   logic               vu_valid;
   logic               vv_valid;
   logic               vw_valid;
   logic signed [DATA_W-1:0] vel_u;
   logic signed [DATA_W-1:0] vel_v;
   logic signed [DATA_W-1:0] vel_w;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
         light_ff <= LIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAMMA: gamma_ff <= csr_wdata[GAMMA_W-1:0];
            CSR_LIGHT: light_ff <= csr_wdata[LIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      side_in.rho  = req_density;
      side_in.en   = req_total_energy;
      side_in.ey   = req_field_e_y;
      side_in.ez   = req_field_e_z;
      side_in.by   = req_field_b_y;
      side_in.bz   = req_field_b_z;
      side_in.last = req_last_in;
      side_in.bad  = req_density <= 0;
   end

   always_ff @(posedge clock) begin
      side_ff[1] <= side_in;
      for (int k = 2; k <= DIV_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   tffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
      .clock(clock), .reset(reset), .in_valid(accept),
      .numer(req_momentum_x), .denom(req_density),
      .out_valid(vu_valid), .quot(vel_u)
   );

   tffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
      .clock(clock), .reset(reset), .in_valid(accept),
      .numer(req_momentum_y), .denom(req_density),
      .out_valid(vv_valid), .quot(vel_v)
   );

   tffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_w (
      .clock(clock), .reset(reset), .in_valid(accept),
      .numer(req_momentum_z), .denom(req_density),
      .out_valid(vw_valid), .quot(vel_w)
   );

   tffv_flux #(.FRAC_BITS(FRAC_BITS)) u_flux (
      .clock(clock), .reset(reset), .in_valid(vu_valid),
      .vel_u(vel_u), .vel_v(vel_v), .vel_w(vel_w),
      .side(side_ff[DIV_LAT]), .gamma_m1(gamma_ff), .c0(light_ff),
      .out_valid(rsp_valid),
      .flux_mass(rsp_flux_mass), .flux_mom_x(rsp_flux_mom_x),
      .flux_mom_y(rsp_flux_mom_y), .flux_mom_z(rsp_flux_mom_z),
      .flux_energy(rsp_flux_energy), .flux_e_y(rsp_flux_e_y),
      .flux_e_z(rsp_flux_e_z), .flux_b_y(rsp_flux_b_y),
      .flux_b_z(rsp_flux_b_z), .bad_density(rsp_bad_density),
      .last_out(rsp_last_out)
   );

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      vu_valid == vv_valid && vu_valid == vw_valid)
      else $error("velocity dividers out of step");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL_LAT))
      else $error("result transfer without a matching request transfer");

endmodule

FILE: test/tb_two_fluid_flux_vector_top.sv
module tb_two_fluid_flux_vector_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tffv_pkg::*;

   localparam int FRAC       = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN      = 60;

   typedef struct packed {
      logic [8:0][31:0] v;
      logic             last;
   } cell_type;

   typedef struct packed {
      logic [8:0][31:0] f;
      logic             bad;
      logic             last;
   } flux_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [8:0][31:0] req_v = '0;
   logic req_last_in = 1'b0;
   logic rsp_valid;
   logic signed [31:0] rsp_f [9];
   logic rsp_bad_density, rsp_last_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   cell_type     cell_queue[$];
   flux_set_type flux_queue[$];
   cell_type     cell_on_port;
   longint    gamma_reg = 43691;
   longint    light_reg = 65536;
   int        errors = 0;
   int        gap_left = 0;
   bit        no_gaps = 1'b0;
   int        idle_cycles = 0;

   always #2 clock = ~clock;

   two_fluid_flux_vector_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_density(req_v[0]), .req_momentum_x(req_v[1]), .req_momentum_y(req_v[2]),
      .req_momentum_z(req_v[3]), .req_total_energy(req_v[4]), .req_field_e_y(req_v[5]),
      .req_field_e_z(req_v[6]), .req_field_b_y(req_v[7]), .req_field_b_z(req_v[8]),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_flux_mass(rsp_f[0]), .rsp_flux_mom_x(rsp_f[1]),
      .rsp_flux_mom_y(rsp_f[2]), .rsp_flux_mom_z(rsp_f[3]), .rsp_flux_energy(rsp_f[4]),
      .rsp_flux_e_y(rsp_f[5]), .rsp_flux_e_z(rsp_f[6]), .rsp_flux_b_y(rsp_f[7]),
      .rsp_flux_b_z(rsp_f[8]), .rsp_bad_density(rsp_bad_density),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint mul_fx(longint a, longint b);
      return clamp32((a * b) / (64'sd1 << FRAC));
   endfunction

   function automatic longint div_fx(longint num, longint den);
      return clamp32((num * (64'sd1 << FRAC)) / den);
   endfunction

   function automatic flux_set_type compute_flux(cell_type c);
      flux_set_type r;
      longint s [9];
      longint u, v, w, q2, kin, p, ru;
      for (int k = 0; k < 9; k++) s[k] = longint'($signed(c.v[k]));
      r = '0;
      r.last = c.last;
      r.bad = (s[0] <= 0);
      if (!r.bad) begin
         u = div_fx(s[1], s[0]);
         v = div_fx(s[2], s[0]);
         w = div_fx(s[3], s[0]);
         q2 = clamp32(mul_fx(u, u) + mul_fx(v, v) + mul_fx(w, w));
         kin = mul_fx(s[0], q2) / 2;
         p = mul_fx(gamma_reg, clamp32(s[4] - kin));
         ru = mul_fx(s[0], u);
         r.f[0] = ru[31:0];
         r.f[1] = 32'(clamp32(mul_fx(ru, u) + p));
         r.f[2] = 32'(mul_fx(ru, v));
         r.f[3] = 32'(mul_fx(ru, w));
         r.f[4] = 32'(mul_fx(clamp32(s[4] + p), u));
      end
      r.f[5] = 32'(mul_fx(light_reg, mul_fx(light_reg, s[8])));
      r.f[6] = 32'(clamp32(-mul_fx(light_reg, mul_fx(light_reg, s[7]))));
      r.f[7] = 32'(clamp32(-s[6]));
      r.f[8] = 32'(s[5]);
      return r;
   endfunction

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(0, 4))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'h1;
         default: return 32'hffffffff;
      endcase
   endfunction

   function automatic logic [31:0] moderate(int span);
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic cell_type make_cell();
      cell_type c;
      int kind;
      kind = $urandom_range(0, 99);
      for (int k = 0; k < 9; k++) c.v[k] = $urandom;
      c.last = 1'($urandom_range(0, 1));
      if (kind < 70) begin
         c.v[0] = $urandom_range(1, 32'h1000000);
         for (int k = 1; k < 4; k++) c.v[k] = moderate(32'h1000000);
         c.v[4] = $urandom_range(0, 32'h4000000);
         if ($urandom_range(0, 3) == 0) c.v[0] = $urandom_range(1, 32'h400);
      end else if (kind < 80) begin
         c.v[0] = -$urandom_range(0, 32'h7fffffff);
      end else if (kind < 90) begin
         for (int k = 0; k < 9; k++) c.v[k] = extreme_value();
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      errors++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GAMMA) gamma_reg = longint'(data & 32'h3ffff);
      else if (idx == CSR_LIGHT) light_reg = longint'(data & 32'h1ffffff);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (cell_queue.size() != 0 || start || flux_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) cell_queue.push_back(make_cell());
   endtask

   // Driver: one transfer per cycle at most, with random gaps between items unless no_gaps is set.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) flux_queue.push_back(compute_flux(cell_on_port));
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (cell_queue.size() != 0) begin
            cell_on_port = cell_queue.pop_front();
            req_v <= cell_on_port.v;
            req_last_in <= cell_on_port.last;
            start <= 1'b1;
            if (no_gaps) gap_left <= 0;
            else if ($urandom_range(0, 99) < 60) gap_left <= 0;
            else if ($urandom_range(0, 99) < 85) gap_left <= $urandom_range(1, 3);
            else gap_left <= $urandom_range(10, 40);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is a result transfer.
   always @(posedge clock) begin
      flux_set_type want;
      if (!reset && rsp_valid) begin
         if (flux_queue.size() == 0) begin
            $display("result transfer with no item outstanding");
            errors++;
         end else begin
            want = flux_queue.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_f[k] !== want.f[k]) report_mismatch($sformatf("flux[%0d]", k),
                                                            rsp_f[k], want.f[k]);
            if (rsp_bad_density !== want.bad) report_mismatch("bad_density",
                                                              32'(rsp_bad_density),
                                                              32'(want.bad));
            if (rsp_last_out !== want.last) report_mismatch("last_out", 32'(rsp_last_out),
                                                            32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)
          || (cell_queue.size() == 0 && flux_queue.size() == 0 && !csr_valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cell_type c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 20; i++) begin
         c = '0;
         c.last = i[0];
         case (i % 10)
            0: c.v = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
            1: c.v = {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
            2: c.v[0] = 32'h0;
            3: begin c.v[0] = 32'h1; c.v[1] = 32'h7fffffff; c.v[4] = 32'h80000000; end
            4: begin c.v[0] = 32'hffffffff; c.v[6] = 32'h80000000; end
            5: begin c.v[0] = 32'h10000; c.v[1] = 32'h20000; c.v[4] = 32'h50000; end
            6: begin c.v[0] = 32'h7fffffff; c.v[1] = 32'h80000000; c.v[4] = 32'h7fffffff; end
            7: begin c.v = '1; c.v[0] = 32'h10000; end
            8: begin c.v[0] = 32'h1; c.v[2] = 32'h80000000; c.v[3] = 32'h7fffffff; end
            default: c = make_cell();
         endcase
         cell_queue.push_back(c);
      end
      run_random(180);
      wait_idle();

      write_register(CSR_GAMMA, 32'h0);
      write_register(CSR_LIGHT, 32'h0);
      no_gaps = 1'b1;
      run_random(200);
      wait_idle();

      write_register(CSR_GAMMA, 32'd131072);
      write_register(CSR_LIGHT, 32'd16777216);
      write_register(CSR_IDX_W'(2), $urandom);
      write_register(CSR_IDX_W'(15), $urandom);
      no_gaps = 1'b0;
      run_random(200);
      wait_idle();

      write_register(CSR_GAMMA, 32'hffffffff);
      write_register(CSR_LIGHT, 32'hffffffff);
      run_random(200);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         write_register(CSR_GAMMA, $urandom);
         write_register(CSR_LIGHT, (ph[0]) ? $urandom : $urandom_range(0, 32'h40000));
         no_gaps = ph[1];
         run_random(100);
         wait_idle();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
